[sv/mbfm_pkg.sv]
package mbfm_pkg;

  typedef enum logic [2:0] {
    FN_BYTE  = 3'd0,
    FN_EOF   = 3'd1,
    FN_TICK  = 3'd2,
    FN_RXERR = 3'd3,
    FN_PULSE = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONV_Q,
    S_CONV_UPD,
    S_FLOW,
    S_CHECK,
    S_JUDGE,
    S_LOAD,
    S_WAIT
  } state_t;

  localparam int REQ_MAX = 8;
  localparam int REQ_IDX_W = $clog2(REQ_MAX);
  localparam logic [7:0] FUNC_READ_HOLD = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] PULSES_PER_DL = 16'd45;
  // floor(x/45) = (x * 46604) >> 21 for any 16-bit x
  localparam logic [15:0] RECIP_45 = 16'd46604;
  localparam int RECIP_45_SH = 21;
  // floor(x/3) = (x * 174763) >> 19 for any 18-bit x
  localparam logic [17:0] RECIP_3 = 18'd174763;
  localparam int RECIP_3_SH = 19;
  localparam int NUM_REGS = 4;

  typedef struct packed {
    logic       init;
    logic       upd;
    logic [7:0] data;
  } crc_ctrl_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

endpackage

[sv/mbfm_crc.sv]
module mbfm_crc
  import mbfm_pkg::*;
(
  input  logic        clk,
  input  crc_ctrl_t   ctrl,
  output logic [15:0] crc
);

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.init) crc_nxt = CRC_INIT;
    else if (ctrl.upd) crc_nxt = crc_byte(crc_r, ctrl.data);
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
  end

  assign crc = crc_r;

endmodule

[sv/modbus_flow_meter_responder_core.sv]
// Flow meter with a Modbus RTU read-holding-registers responder. Each input word
// carries a kind in in_tuser and passes through S_CONV_Q and S_CONV_UPD (and then
// S_FLOW for a tick) before in_tready returns. An end of frame that holds a valid
// request then feeds the first six request bytes through the byte-wide crc unit in
// S_CHECK and is judged in S_JUDGE; each response byte (5 to 13 bytes) then takes
// S_LOAD and S_WAIT plus any output stall, as the single output register and the
// shared crc unit require. No input is taken while a response is being sent.
module modbus_flow_meter_responder_core
  import mbfm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rx_byte[7:0], pulse_count[23:8], address_straps[25:24]
  input  logic [2:0]  in_tuser,   // func[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast
);

  state_t state_r, state_nxt;

  logic [2:0]  func_r;
  logic [7:0]  byte_r;
  logic [15:0] cnt_r;
  logic [1:0]  straps_r;
  logic [15:0] diff_r;
  logic [10:0] q_r, q_nxt;

  logic [7:0]  req_r [REQ_MAX];
  logic [3:0]  len_r, len_nxt;
  logic [15:0] conv_r, conv_nxt;
  logic [31:0] total_r, total_nxt;
  logic [15:0] last_r, last_nxt;
  logic [15:0] pps_r, pps_nxt;
  logic [15:0] flow_r, flow_nxt;
  logic [15:0] errs_r, errs_nxt;
  logic [2:0]  addr_r, addr_nxt;
  logic [REQ_IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]  start_r, start_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  od_r, od_nxt;
  logic        ol_r, ol_nxt;
  logic        req_we;

  crc_ctrl_t   crc_ctrl;
  logic [15:0] crc;

  logic [31:0] q_prod;
  logic [35:0] flow_prod;
  logic [17:0] flow_x;
  logic [15:0] start16, count16;
  logic [16:0] span;
  logic        req_ok;
  logic [3:0]  nbytes, rel;
  logic [1:0]  ri;
  logic [15:0] reg_val;
  logic [7:0]  tx_byte;

  mbfm_crc u_crc (.clk(clk), .ctrl(crc_ctrl), .crc(crc));

  assign q_prod    = diff_r * RECIP_45;
  assign q_nxt     = q_prod[RECIP_45_SH +: 11];
  assign flow_x    = {pps_r, 2'b00} + 18'd1;
  assign flow_prod = flow_x * RECIP_3;

  assign start16 = {req_r[2], req_r[3]};
  assign count16 = {req_r[4], req_r[5]};
  assign span    = {1'b0, start16} + {1'b0, count16};
  assign req_ok  = (req_r[0] == {5'd0, addr_r}) && (req_r[1] == FUNC_READ_HOLD) &&
                   (crc == {req_r[7], req_r[6]}) && (span <= 17'(NUM_REGS));

  // response byte selection
  assign nbytes = 4'd5 + {count_r, 1'b0};
  assign rel    = k_r - 4'd3;
  assign ri     = 2'(start_r + {1'b0, rel[3:2], rel[1]});

  always_comb begin
    unique case (ri)
      2'd0: reg_val = total_r[31:16];
      2'd1: reg_val = total_r[15:0];
      2'd2: reg_val = flow_r;
      default: reg_val = errs_r;
    endcase
  end

  always_comb begin
    if (k_r == 4'd0) tx_byte = {5'd0, addr_r};
    else if (k_r == 4'd1) tx_byte = FUNC_READ_HOLD;
    else if (k_r == 4'd2) tx_byte = {4'd0, count_r, 1'b0};
    else if (k_r == nbytes - 4'd2) tx_byte = crc[7:0];
    else if (k_r == nbytes - 4'd1) tx_byte = crc[15:8];
    else if (rel[0]) tx_byte = reg_val[7:0];
    else tx_byte = reg_val[15:8];
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    conv_nxt   = conv_r;
    total_nxt  = total_r;
    last_nxt   = last_r;
    pps_nxt    = pps_r;
    flow_nxt   = flow_r;
    errs_nxt   = errs_r;
    addr_nxt   = addr_r;
    idx_nxt    = idx_r;
    start_nxt  = start_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    ov_nxt     = ov_r;
    od_nxt     = od_r;
    ol_nxt     = ol_r;
    req_we     = 1'b0;
    crc_ctrl   = '{init: 1'b0, upd: 1'b0, data: 8'h00};
    in_tready  = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_CONV_Q;
      end
      S_CONV_Q: state_nxt = S_CONV_UPD;
      S_CONV_UPD: begin
        conv_nxt  = conv_r + 16'(q_r) * PULSES_PER_DL;
        total_nxt = total_r + 32'(q_r);
        state_nxt = S_IDLE;
        case (func_r)
          FN_BYTE: begin
            if (len_r < 4'(REQ_MAX)) begin
              req_we  = 1'b1;
              len_nxt = len_r + 4'd1;
            end
          end
          FN_EOF: begin
            len_nxt = '0;
            if (len_r == 4'(REQ_MAX)) begin
              crc_ctrl.init = 1'b1;
              idx_nxt       = '0;
              state_nxt     = S_CHECK;
            end
          end
          FN_TICK: begin
            pps_nxt   = cnt_r - last_r;
            last_nxt  = cnt_r;
            addr_nxt  = 3'd1 + {1'b0, straps_r};
            state_nxt = S_FLOW;
          end
          FN_RXERR: begin
            errs_nxt = errs_r + 16'd1;
            len_nxt  = '0;
          end
          default: ;
        endcase
      end
      S_FLOW: begin
        flow_nxt  = flow_prod[RECIP_3_SH +: 16];
        state_nxt = S_IDLE;
      end
      S_CHECK: begin
        crc_ctrl.upd  = 1'b1;
        crc_ctrl.data = req_r[idx_r];
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == REQ_IDX_W'(5)) state_nxt = S_JUDGE;
      end
      S_JUDGE: begin
        start_nxt     = req_r[3][2:0];
        count_nxt     = req_r[5][2:0];
        k_nxt         = '0;
        crc_ctrl.init = 1'b1;
        state_nxt     = req_ok ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        od_nxt = tx_byte;
        ol_nxt = (k_r == nbytes - 4'd1);
        ov_nxt = 1'b1;
        if (k_r < nbytes - 4'd2) begin
          crc_ctrl.upd  = 1'b1;
          crc_ctrl.data = tx_byte;
        end
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (out_tready) begin
          ov_nxt    = 1'b0;
          k_nxt     = k_r + 4'd1;
          state_nxt = ol_r ? S_IDLE : S_LOAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      conv_r  <= '0;
      total_r <= '0;
      last_r  <= '0;
      pps_r   <= '0;
      flow_r  <= '0;
      errs_r  <= '0;
      addr_r  <= 3'd1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      conv_r  <= conv_nxt;
      total_r <= total_nxt;
      last_r  <= last_nxt;
      pps_r   <= pps_nxt;
      flow_r  <= flow_nxt;
      errs_r  <= errs_nxt;
      addr_r  <= addr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      func_r   <= in_tuser;
      byte_r   <= in_tdata[7:0];
      cnt_r    <= in_tdata[23:8];
      straps_r <= in_tdata[25:24];
      diff_r   <= in_tdata[23:8] - conv_r;
    end
    q_r     <= q_nxt;
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    count_r <= count_nxt;
    k_r     <= k_nxt;
    od_r    <= od_nxt;
    ol_r    <= ol_nxt;
    if (req_we) req_r[len_r[REQ_IDX_W-1:0]] <= byte_r;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while a byte is pending");
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= 4'(REQ_MAX)) else $error("request length overflow");
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CONV_Q)) else $error("conversion skipped");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (state_r == S_IDLE))
    else $error("response did not end on last byte");

endmodule
